// File: hw/rtl/u8s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitizer package
// Shared constants and the result-run type of the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
package u8s_pkg;

    localparam int RUN_MAX = 6;
    localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);

    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hBF;
    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD2_HI   = 8'hDF;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD3_HI   = 8'hEF;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] LEAD4_HI   = 8'hF4;
    localparam logic [7:0] LEAD_SURR  = 8'hED;
    localparam logic [7:0] E0_LO      = 8'hA0;
    localparam logic [7:0] ED_HI      = 8'h9F;
    localparam logic [7:0] F0_LO      = 8'h90;
    localparam logic [7:0] F4_HI      = 8'h8F;
    localparam logic [7:0] REPL_B0    = 8'hEF;
    localparam logic [7:0] REPL_B1    = 8'hBF;
    localparam logic [7:0] REPL_B2    = 8'hBD;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_MAX-1:0]      repl;
        logic [RUN_CNT_W-1:0]    cnt;
    } t_run;

endpackage

// File: hw/rtl/u8s_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitizer channels
// Valid/ready channels for raw input bytes and sanitized output bytes.
// ----------------------------------------------------------------------------
interface u8s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface u8s_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
    logic       is_replacement;

    modport source (output valid, output out_byte, output run_last,
                    output stream_end, output is_replacement, input ready);
    modport sink (input valid, input out_byte, input run_last,
                  input stream_end, input is_replacement, output ready);
endinterface

// File: hw/rtl/u8s_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitizer scanner
// Holds the partial sequence and turns one input byte into its result run.
// ----------------------------------------------------------------------------
module u8s_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output u8s_pkg::t_run o_run
);

    logic [1:0]      r_pc;
    logic [1:0]      r_need;
    logic [2:0][7:0] r_pend;
    logic [1:0]      n_pc;
    logic [1:0]      n_need;
    logic [2:0][7:0] n_pend;

    u8s_pkg::t_run run;
    logic [7:0]    lo;
    logic [7:0]    hi;
    logic          do_lead;

    always_comb begin
        n_pc    = r_pc;
        n_need  = r_need;
        n_pend  = r_pend;
        run     = '0;
        do_lead = 1'b0;
        lo      = u8s_pkg::CONT_LO;
        hi      = u8s_pkg::CONT_HI;

        if (r_pc == 2'd0 || r_need == 2'd0) begin
            n_pc    = 2'd0;
            n_need  = 2'd0;
            do_lead = 1'b1;
        end else begin
            if (r_pc == 2'd1) begin
                if (r_pend[0] == u8s_pkg::LEAD3_LO) lo = u8s_pkg::E0_LO;
                if (r_pend[0] == u8s_pkg::LEAD_SURR) hi = u8s_pkg::ED_HI;
                if (r_pend[0] == u8s_pkg::LEAD4_LO) lo = u8s_pkg::F0_LO;
                if (r_pend[0] == u8s_pkg::LEAD4_HI) hi = u8s_pkg::F4_HI;
            end
            if (i_byte >= lo && i_byte <= hi) begin
                if (r_need == 2'd1) begin
                    for (int k = 0; k < 3; k++) begin
                        if (k < int'(r_pc)) begin
                            run.bytes[run.cnt] = r_pend[k];
                            run.cnt = run.cnt + 1'b1;
                        end
                    end
                    run.bytes[run.cnt] = i_byte;
                    run.cnt = run.cnt + 1'b1;
                    n_pc   = 2'd0;
                    n_need = 2'd0;
                end else begin
                    n_pend[r_pc] = i_byte;
                    n_pc   = r_pc + 2'd1;
                    n_need = r_need - 2'd1;
                end
            end else begin
                run.bytes[run.cnt] = u8s_pkg::REPL_B0;
                run.repl[run.cnt]  = 1'b1;
                run.cnt = run.cnt + 1'b1;
                run.bytes[run.cnt] = u8s_pkg::REPL_B1;
                run.repl[run.cnt]  = 1'b1;
                run.cnt = run.cnt + 1'b1;
                run.bytes[run.cnt] = u8s_pkg::REPL_B2;
                run.repl[run.cnt]  = 1'b1;
                run.cnt = run.cnt + 1'b1;
                n_pc    = 2'd0;
                n_need  = 2'd0;
                do_lead = 1'b1;
            end
        end

        if (do_lead) begin
            if (i_byte < u8s_pkg::CONT_LO) begin
                run.bytes[run.cnt] = i_byte;
                run.cnt = run.cnt + 1'b1;
            end else if (i_byte inside {[u8s_pkg::LEAD2_LO:u8s_pkg::LEAD2_HI]}) begin
                n_pend[0] = i_byte;
                n_pc      = 2'd1;
                n_need    = 2'd1;
            end else if (i_byte inside {[u8s_pkg::LEAD3_LO:u8s_pkg::LEAD3_HI]}) begin
                n_pend[0] = i_byte;
                n_pc      = 2'd1;
                n_need    = 2'd2;
            end else if (i_byte inside {[u8s_pkg::LEAD4_LO:u8s_pkg::LEAD4_HI]}) begin
                n_pend[0] = i_byte;
                n_pc      = 2'd1;
                n_need    = 2'd3;
            end else begin
                run.bytes[run.cnt] = u8s_pkg::REPL_B0;
                run.repl[run.cnt]  = 1'b1;
                run.cnt = run.cnt + 1'b1;
                run.bytes[run.cnt] = u8s_pkg::REPL_B1;
                run.repl[run.cnt]  = 1'b1;
                run.cnt = run.cnt + 1'b1;
                run.bytes[run.cnt] = u8s_pkg::REPL_B2;
                run.repl[run.cnt]  = 1'b1;
                run.cnt = run.cnt + 1'b1;
            end
        end

        if (i_last && n_pc != 2'd0) begin
            run.bytes[run.cnt] = u8s_pkg::REPL_B0;
            run.repl[run.cnt]  = 1'b1;
            run.cnt = run.cnt + 1'b1;
            run.bytes[run.cnt] = u8s_pkg::REPL_B1;
            run.repl[run.cnt]  = 1'b1;
            run.cnt = run.cnt + 1'b1;
            run.bytes[run.cnt] = u8s_pkg::REPL_B2;
            run.repl[run.cnt]  = 1'b1;
            run.cnt = run.cnt + 1'b1;
            n_pc   = 2'd0;
            n_need = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= 2'd0;
            r_need <= 2'd0;
        end else if (i_take) begin
            r_pc   <= n_pc;
            r_need <= n_need;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_pend <= n_pend;
        end
    end

    assign o_run = run;

endmodule

// File: hw/rtl/utf8_sanitizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitizer core
// Turns an arbitrary byte stream into well-formed UTF-8.
// ----------------------------------------------------------------------------
// Raw bytes arrive on i_in with in_last marking the final byte of a stream.
// Sanitized bytes leave on o_out; run_last marks the last output byte caused
// by one input beat, and stream_end the last output byte of a stream.
// Each accepted byte is scanned in the cycle it is accepted, and its output
// run (zero to six bytes) is loaded into an output register. The first byte
// of a run is offered on o_out in the cycle after its input beat. The output
// side moves one byte per cycle while the receiver is ready. A new input
// beat is taken whenever the output register is empty or is handing over its
// final byte, so plain text flows at one byte per cycle if neither side
// stalls; a longer run holds the input side until its last byte leaves.
// Bytes of a multibyte sequence yield nothing until the sequence completes
// or its stream ends. When the receiver stalls, the current output byte
// holds and the input side stalls for as long as any output byte is waiting.
// Reset clears the partial sequence and empties the output register.
// ----------------------------------------------------------------------------
module utf8_sanitizer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8s_in_if.sink    i_in,
    u8s_out_if.source o_out
);

    u8s_pkg::t_run                  scan_run;
    u8s_pkg::t_run                  r_run;
    logic [u8s_pkg::RUN_CNT_W-1:0]  r_cnt;
    logic [u8s_pkg::RUN_CNT_W-1:0]  r_idx;
    logic                           r_last;
    logic                           take;
    logic                           beat_out;
    logic                           last_beat;

    assign last_beat = (r_idx == r_cnt - 1'b1);
    assign beat_out  = o_out.valid && o_out.ready;
    assign i_in.ready = (r_cnt == '0) || (o_out.ready && last_beat);
    assign take = i_in.valid && i_in.ready;

    u8s_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in.in_byte),
        .i_last  (i_in.in_last),
        .o_run   (scan_run)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (take) begin
            r_cnt <= scan_run.cnt;
            r_idx <= '0;
        end else if (beat_out) begin
            if (last_beat) begin
                r_cnt <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_run  <= scan_run;
            r_last <= i_in.in_last;
        end
    end

    assign o_out.valid          = (r_cnt != '0);
    assign o_out.out_byte       = r_run.bytes[r_idx];
    assign o_out.is_replacement = r_run.repl[r_idx];
    assign o_out.run_last       = last_beat;
    assign o_out.stream_end     = last_beat && r_last;

endmodule

// File: tb/utf8_sanitizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitizer checker
// Watches both channels of the sanitizer, keeps its own copy of the decoder
// state to predict the output run of every accepted input beat, and compares
// each output beat field by field against the oldest predicted byte.
// ----------------------------------------------------------------------------
module utf8_sanitizer_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    u8s_in_if    i_in,
    u8s_out_if   i_out,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_beats_in,
    output int   o_bytes_out,
    output int   o_streams,
    output int   o_repl_bytes
);
    import u8s_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       stream_end;
        logic       repl;
    } t_san_byte;

    t_san_byte  expected_bytes[$];
    t_san_byte  run_buf[RUN_MAX];
    int         run_len;
    logic [7:0] held_bytes[3];
    int         held_count;
    int         cont_needed;

    function automatic void append_expected(t_san_byte sb);
        expected_bytes.insert(expected_bytes.size(), sb);
    endfunction

    function automatic void add_run_byte(logic [7:0] b, logic repl);
        run_buf[run_len] = '{b, 1'b0, 1'b0, repl};
        run_len++;
    endfunction

    function automatic void add_fffd();
        add_run_byte(REPL_B0, 1'b1);
        add_run_byte(REPL_B1, 1'b1);
        add_run_byte(REPL_B2, 1'b1);
    endfunction

    function automatic void take_lead(logic [7:0] b);
        if (b < CONT_LO) begin
            add_run_byte(b, 1'b0);
            return;
        end
        if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            cont_needed = 1;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            cont_needed = 2;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            cont_needed = 3;
        end else begin
            add_fffd();
            return;
        end
        held_bytes[0] = b;
        held_count = 1;
    endfunction

    function automatic void sanitize_byte(logic [7:0] b, logic last);
        logic [7:0] lo;
        logic [7:0] hi;
        run_len = 0;
        if (held_count == 0 || cont_needed == 0) begin
            held_count = 0;
            cont_needed = 0;
            take_lead(b);
        end else begin
            lo = CONT_LO;
            hi = CONT_HI;
            if (held_count == 1) begin
                case (held_bytes[0])
                    LEAD3_LO: lo = E0_LO;
                    LEAD_SURR: hi = ED_HI;
                    LEAD4_LO: lo = F0_LO;
                    LEAD4_HI: hi = F4_HI;
                    default: ;
                endcase
            end
            if (b >= lo && b <= hi) begin
                cont_needed--;
                if (cont_needed == 0) begin
                    for (int k = 0; k < held_count; k++) begin
                        add_run_byte(held_bytes[k], 1'b0);
                    end
                    add_run_byte(b, 1'b0);
                    held_count = 0;
                end else begin
                    held_bytes[held_count] = b;
                    held_count++;
                end
            end else begin
                // The buffered valid prefix becomes one replacement and the
                // offending byte is scanned again as a lead.
                add_fffd();
                held_count = 0;
                cont_needed = 0;
                take_lead(b);
            end
        end
        if (last && held_count != 0) begin
            add_fffd();
            held_count = 0;
            cont_needed = 0;
        end
        if (run_len > 0) begin
            run_buf[run_len - 1].run_last = 1'b1;
            run_buf[run_len - 1].stream_end = last;
        end
        for (int k = 0; k < run_len; k++) begin
            append_expected(run_buf[k]);
        end
    endfunction

    function automatic void report_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (exp_v !== got_v) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %02h, got %02h",
                     $time, name, exp_v, got_v);
        end
    endfunction

    function automatic void check_byte(t_san_byte got);
        t_san_byte exp_b;
        if (expected_bytes.size() == 0) begin
            o_fail_count++;
            $display("%0t: unexpected output beat, expected none, got %02h",
                     $time, got.data);
            return;
        end
        exp_b = expected_bytes.pop_front();
        report_field("out_byte", exp_b.data, got.data);
        report_field("run_last", {7'd0, exp_b.run_last}, {7'd0, got.run_last});
        report_field("stream_end", {7'd0, exp_b.stream_end}, {7'd0, got.stream_end});
        report_field("is_replacement", {7'd0, exp_b.repl}, {7'd0, got.repl});
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_bytes.delete();
            held_count = 0;
            cont_needed = 0;
            o_fail_count = 0;
            o_beats_in = 0;
            o_bytes_out = 0;
            o_streams = 0;
            o_repl_bytes = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                check_byte('{i_out.out_byte, i_out.run_last, i_out.stream_end,
                             i_out.is_replacement});
                o_bytes_out++;
                if (i_out.stream_end) begin
                    o_streams++;
                end
                if (i_out.is_replacement) begin
                    o_repl_bytes++;
                end
            end
            if (i_in.valid && i_in.ready) begin
                sanitize_byte(i_in.in_byte, i_in.in_last);
                o_beats_in++;
            end
        end
        o_outstanding = expected_bytes.size();
    end

endmodule

// File: tb/utf8_sanitizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitizer core testbench
// Drives byte streams into the sanitizer: a directed opening with boundary
// sequences and every kind of ill-formed input, then random streams built
// mostly from well-formed characters with truncated and corrupted ones mixed
// in. Both sides idle at random in two phases, then one long receiver stall
// backs the block up. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module utf8_sanitizer_core_tb;
    import u8s_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_stim_beat;

    localparam int PHASE_BEATS = 120;
    localparam int LONG_HOLD = 120;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;

    u8s_in_if  in_ch ();
    u8s_out_if out_ch ();

    int         src_idle_pct;
    int         sink_idle_pct;
    bit         long_hold_req;
    t_stim_beat stim_q[$];

    int fail_count;
    int outstanding;
    int beats_in;
    int bytes_out;
    int streams_done;
    int repl_bytes;

    utf8_sanitizer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    utf8_sanitizer_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_beats_in    (beats_in),
        .o_bytes_out   (bytes_out),
        .o_streams     (streams_done),
        .o_repl_bytes  (repl_bytes)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("FAIL utf8_sanitizer_core");
        $finish;
    end

    // Receiver: random back-pressure, or one long stall when requested.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic void queue_beat(input logic [7:0] b, input logic last);
        t_stim_beat beat;
        beat.data = b;
        beat.last = last;
        stim_q.insert(stim_q.size(), beat);
    endfunction

    // Appends one character: ASCII, a multibyte sequence, or noise. Some
    // multibyte sequences are cut short or get a random byte in place of a
    // continuation, and some characters close the stream.
    task automatic add_symbol();
        logic [7:0] seq[4];
        int         len;
        int         keep;
        int         kind;
        int         mode;
        int         end_pct;
        kind = $urandom_range(99);
        len = 1;
        if (kind < 10) begin
            seq[0] = 8'($urandom_range(255));
        end else if (kind < 35) begin
            seq[0] = 8'($urandom_range(127));
        end else if (kind < 55) begin
            seq[0] = 8'($urandom_range(LEAD2_HI, LEAD2_LO));
            len = 2;
        end else if (kind < 80) begin
            seq[0] = 8'($urandom_range(LEAD3_HI, LEAD3_LO));
            len = 3;
        end else begin
            seq[0] = 8'($urandom_range(LEAD4_HI, LEAD4_LO));
            len = 4;
        end
        for (int i = 1; i < len; i++) begin
            seq[i] = 8'($urandom_range(CONT_HI, CONT_LO));
        end
        if (len > 1) begin
            case (seq[0])
                LEAD3_LO: seq[1] = 8'($urandom_range(CONT_HI, E0_LO));
                LEAD_SURR: seq[1] = 8'($urandom_range(ED_HI, CONT_LO));
                LEAD4_LO: seq[1] = 8'($urandom_range(CONT_HI, F0_LO));
                LEAD4_HI: seq[1] = 8'($urandom_range(F4_HI, CONT_LO));
                default: ;
            endcase
        end
        keep = len;
        if (len > 1) begin
            mode = $urandom_range(99);
            if (mode < 12) begin
                keep = $urandom_range(len - 1, 1);
            end else if (mode < 24) begin
                seq[$urandom_range(len - 1, 1)] = 8'($urandom_range(255));
            end
        end
        end_pct = (keep < len) ? 40 : 6;
        for (int i = 0; i < keep; i++) begin
            queue_beat(seq[i], (i == keep - 1) && ($urandom_range(99) < end_pct));
        end
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input bit with_hold);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        if (with_hold) begin
            long_hold_req = 1'b1;
        end
        while (stim_q.size() < PHASE_BEATS) add_symbol();
        foreach (stim_q[i]) begin
            send_beat(stim_q[i].data, stim_q[i].last);
        end
        stim_q.delete();
    endtask

    initial begin
        logic [7:0] intro_bytes[27];
        intro_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'hBF,
                        8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h80, 8'hC0, 8'hF5,
                        8'hE0, 8'h9F, 8'hED, 8'hA0, 8'hF0, 8'h8F, 8'hF4,
                        8'h90, 8'hE1, 8'h80, 8'h41, 8'hE2, 8'h82};
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        src_idle_pct = 0;
        sink_idle_pct = 0;
        long_hold_req = 1'b0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The directed opening ends on an unfinished sequence marked last.
        foreach (intro_bytes[i]) begin
            queue_beat(intro_bytes[i], i == $size(intro_bytes) - 1);
        end
        run_phase(14, 85, 1'b0);
        run_phase(85, 14, 1'b0);
        run_phase(0, 0, 1'b1);

        in_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d input beats and %0d output bytes over %0d finished streams,",
                 beats_in, bytes_out, streams_done);
        $display("with %0d replacement bytes and one long output stall.", repl_bytes);
        if (fail_count == 0) begin
            $display("PASS utf8_sanitizer_core");
        end else begin
            $display("FAIL utf8_sanitizer_core");
        end
        $finish;
    end

endmodule

// File: utf8_sanitizer_core.f
hw/rtl/u8s_pkg.sv
hw/rtl/u8s_if.sv
hw/rtl/u8s_scan.sv
hw/rtl/utf8_sanitizer_core.sv
tb/utf8_sanitizer_checker.sv
tb/utf8_sanitizer_core_tb.sv
